// File: rtl/qvt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_pkg: shared types and constants of the quad vertex transform
// Register indexes, mode and axis codes, reset values, configuration struct
// and the operation code that the front passes to the back with each quad.
// ----------------------------------------------------------------------------
package qvt_pkg;

   localparam int VERTEX_COUNT = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int CSR_IDX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int PIVOT_BITS   = 12;

   // register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_MODE         = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_X      = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SCALE_Y      = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROTATE_COS   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ROTATE_SIN   = 3'd4;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIVOT_DX     = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PIVOT_DY     = 3'd6;
   localparam logic [CSR_IDX_BITS-1:0] CSR_REFLECT_AXIS = 3'd7;

   localparam logic [1:0] MODE_SCALE   = 2'd0;
   localparam logic [1:0] MODE_ROTATE  = 2'd1;
   localparam logic [1:0] MODE_REFLECT = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;  // negate y
   localparam logic [1:0] AXIS_Y = 2'd1;  // negate x

   localparam logic signed [15:0] SCALE_RESET = 16'sd4096;
   localparam logic signed [15:0] COS_RESET   = 16'sd16384;

   typedef enum logic [1:0] {
      OP_SCALE  = 2'd0,
      OP_ROTATE = 2'd1,
      OP_NEG_Y  = 2'd2,
      OP_NEG_X  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                   mode;
      logic signed [15:0]           scale_x;
      logic signed [15:0]           scale_y;
      logic signed [15:0]           rotate_cos;
      logic signed [15:0]           rotate_sin;
      logic signed [PIVOT_BITS-1:0] pivot_dx;
      logic signed [PIVOT_BITS-1:0] pivot_dy;
      logic [1:0]                   reflect_axis;
   } cfg_type;

endpackage
`default_nettype wire

// File: rtl/qvt_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_front: vertex loader and classifier
// Collects three vertices with running sums; on the fourth beat it decides
// the operation and pushes the whole quad into the queue, or drops it.
// ----------------------------------------------------------------------------
module qvt_front #(
   parameter int COORD_BITS = 12,
   parameter int DATA_BITS  = 2 + 10 * COORD_BITS + 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire signed [COORD_BITS-1:0]  vertex_x,
   input  wire signed [COORD_BITS-1:0]  vertex_y,
   input  qvt_pkg::cfg_type             cfg,
   output logic                         push,
   output logic [DATA_BITS-1:0]         push_data
);
   import qvt_pkg::*;

   localparam int SW = COORD_BITS + 2;

   logic signed [COORD_BITS-1:0] x_ff [0:VERTEX_COUNT-2];
   logic signed [COORD_BITS-1:0] y_ff [0:VERTEX_COUNT-2];
   logic [1:0]                   load_count_ff, load_count_in;
   logic signed [SW-1:0]         sum_x_ff, sum_x_in, sum_y_ff, sum_y_in;
   logic                         last_slot;
   logic                         emit;
   op_type                       op;

   assign last_slot     = (load_count_ff == 2'(VERTEX_COUNT - 1));
   assign load_count_in = accept ? load_count_ff + 2'd1 : load_count_ff;
   assign sum_x_in = ((load_count_ff == 2'd0) ? SW'(0) : sum_x_ff) + SW'(vertex_x);
   assign sum_y_in = ((load_count_ff == 2'd0) ? SW'(0) : sum_y_ff) + SW'(vertex_y);

   always_comb begin
      emit = 1'b1;
      op   = OP_SCALE;
      case (cfg.mode)
         MODE_SCALE:  op = OP_SCALE;
         MODE_ROTATE: op = OP_ROTATE;
         MODE_REFLECT: begin
            case (cfg.reflect_axis)
               AXIS_X:  op = OP_NEG_Y;
               AXIS_Y:  op = OP_NEG_X;
               default: emit = 1'b0;
            endcase
         end
         default: emit = 1'b0;
      endcase
   end

   assign push      = accept && last_slot && emit;
   assign push_data = {op, sum_y_in, sum_x_in,
                       vertex_y, y_ff[2], y_ff[1], y_ff[0],
                       vertex_x, x_ff[2], x_ff[1], x_ff[0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= 2'd0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         if (!last_slot) begin
            x_ff[load_count_ff] <= vertex_x;
            y_ff[load_count_ff] <= vertex_y;
         end
      end
   end

endmodule
`default_nettype wire

// File: rtl/qvt_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_queue: quad queue between front and back
// Two-entry first-in first-out buffer of whole quads.
// ----------------------------------------------------------------------------
module qvt_queue #(
   parameter int DATA_BITS = 126
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  wire [DATA_BITS-1:0]  push_data,
   input  wire                  pop,
   output logic                 full,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] head_data
);
   import qvt_pkg::*;

   logic [DATA_BITS-1:0] entry_ff [0:QUEUE_DEPTH-1];
   logic                 wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign not_empty = (count_ff != 2'd0);
   assign head_data = entry_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
   assign rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
   assign count_in  = count_ff + 2'(push) - 2'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("quad queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !not_empty)) else $error("quad queue underflow");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(QUEUE_DEPTH)) else $error("quad queue count out of range");

endmodule
`default_nettype wire

// File: rtl/qvt_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qvt_back: per-vertex transform pipeline
// Walks the head quad one vertex per cycle: offset stage, multiply stage,
// then round, saturate and the result register.
// ----------------------------------------------------------------------------
module qvt_back #(
   parameter int COORD_BITS = 12,
   parameter int DATA_BITS  = 2 + 10 * COORD_BITS + 4
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          head_valid,
   input  wire [DATA_BITS-1:0]          head_data,
   input  qvt_pkg::cfg_type             cfg,
   output logic                         pop,
   output logic                         rsp_valid,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_last_of_run
);
   import qvt_pkg::*;

   localparam int CB = COORD_BITS;
   localparam int SW = CB + 2;                           // quad sum
   localparam int OW = ((CB > PIVOT_BITS) ? CB : PIVOT_BITS) + 3; // origin, quarters
   localparam int XW = OW + 1;                           // 4*v - origin
   localparam int DW = OW - 1;                           // offset from origin
   localparam int PW = DW + 16;                          // product
   localparam int VW = PW + 2;                           // pre-round sum

   // ---- head unpack and vertex select ----
   logic [1:0]           idx_ff;
   logic signed [CB-1:0] sel_x, sel_y;
   logic signed [SW-1:0] q_sx, q_sy;
   op_type               q_op;
   logic signed [OW-1:0] ox4, oy4;
   logic signed [DW-1:0] dx, dy;

   assign sel_x = $signed(head_data[idx_ff*CB +: CB]);
   assign sel_y = $signed(head_data[4*CB + idx_ff*CB +: CB]);
   assign q_sx  = $signed(head_data[8*CB +: SW]);
   assign q_sy  = $signed(head_data[8*CB+SW +: SW]);
   assign q_op  = op_type'(head_data[DATA_BITS-1 -: 2]);
   assign pop   = head_valid && (idx_ff == 2'(VERTEX_COUNT - 1));

   assign ox4 = OW'(q_sx) + (OW'(cfg.pivot_dx) <<< 2);
   assign oy4 = OW'(q_sy) + (OW'(cfg.pivot_dy) <<< 2);

   // (4*v - o4) / 4, truncated toward zero
   function automatic logic signed [DW-1:0] rel_quarter(input logic signed [CB-1:0] v,
                                                        input logic signed [OW-1:0] o4);
      logic signed [XW-1:0] diff;
      logic signed [XW-1:0] biased;
      diff   = (XW'(v) <<< 2) - XW'(o4);
      biased = diff + (diff[XW-1] ? XW'(3) : XW'(0));
      return $signed(biased[XW-1:2]);
   endfunction

   assign dx = rel_quarter(sel_x, ox4);
   assign dy = rel_quarter(sel_y, oy4);

   // ---- stage A ----
   logic                 a_valid_ff;
   logic [1:0]           a_idx_ff;
   op_type               a_op_ff;
   logic signed [DW-1:0] a_x_ff, a_y_ff;
   logic signed [OW-1:0] a_ox4_ff, a_oy4_ff;

   // ---- stage B ----
   logic                 b_valid_ff;
   logic [1:0]           b_idx_ff;
   op_type               b_op_ff;
   logic signed [PW-1:0] b_p0_ff, b_p1_ff, b_p2_ff, b_p3_ff;
   logic signed [DW-1:0] b_x_ff, b_y_ff;
   logic signed [OW-1:0] b_ox4_ff, b_oy4_ff;
   logic signed [15:0]   coef_x, coef_y;
   logic signed [PW-1:0] m0, m1, m2, m3;

   assign coef_x = (a_op_ff == OP_ROTATE) ? cfg.rotate_cos : cfg.scale_x;
   assign coef_y = (a_op_ff == OP_ROTATE) ? cfg.rotate_cos : cfg.scale_y;
   assign m0 = PW'(a_x_ff) * PW'(coef_x);
   assign m1 = PW'(a_y_ff) * PW'(cfg.rotate_sin);
   assign m2 = PW'(a_x_ff) * PW'(cfg.rotate_sin);
   assign m3 = PW'(a_y_ff) * PW'(coef_y);

   // ---- stage C: round and saturate ----
   logic signed [VW-1:0] rx, ry;
   logic                 rsp_valid_ff, rsp_last_ff;
   logic signed [CB-1:0] rsp_x_ff, rsp_y_ff;

   function automatic logic signed [CB-1:0] sat_coord(input logic signed [VW-1:0] v);
      logic signed [VW-1:0] hi;
      logic signed [VW-1:0] lo;
      hi = VW'((2 ** (CB - 1)) - 1);
      lo = -hi - VW'(1);
      if (v > hi) begin
         return hi[CB-1:0];
      end else if (v < lo) begin
         return lo[CB-1:0];
      end
      return v[CB-1:0];
   endfunction

   always_comb begin
      rx = VW'(b_x_ff);
      ry = VW'(b_y_ff);
      case (b_op_ff)
         OP_SCALE: begin
            rx = (VW'(b_p0_ff) + VW'(2048)) >>> 12;
            ry = (VW'(b_p3_ff) + VW'(2048)) >>> 12;
         end
         OP_ROTATE: begin
            rx = (VW'(b_p0_ff) - VW'(b_p1_ff) + (VW'(b_ox4_ff) <<< 12) + VW'(8192)) >>> 14;
            ry = (VW'(b_p2_ff) + VW'(b_p3_ff) + (VW'(b_oy4_ff) <<< 12) + VW'(8192)) >>> 14;
         end
         OP_NEG_Y: ry = -VW'(b_y_ff);
         OP_NEG_X: rx = -VW'(b_x_ff);
         default: begin
            rx = VW'(b_x_ff);
            ry = VW'(b_y_ff);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         if (head_valid) begin
            idx_ff <= idx_ff + 2'd1;
         end
         a_valid_ff   <= head_valid;
         b_valid_ff   <= a_valid_ff;
         rsp_valid_ff <= b_valid_ff;
         rsp_last_ff  <= b_valid_ff && (b_idx_ff == 2'(VERTEX_COUNT - 1));
      end
   end

   always_ff @(posedge clock) begin
      a_idx_ff <= idx_ff;
      a_op_ff  <= q_op;
      a_x_ff   <= (q_op == OP_ROTATE) ? dx : DW'(sel_x);
      a_y_ff   <= (q_op == OP_ROTATE) ? dy : DW'(sel_y);
      a_ox4_ff <= ox4;
      a_oy4_ff <= oy4;

      b_idx_ff <= a_idx_ff;
      b_op_ff  <= a_op_ff;
      b_p0_ff  <= m0;
      b_p1_ff  <= m1;
      b_p2_ff  <= m2;
      b_p3_ff  <= m3;
      b_x_ff   <= a_x_ff;
      b_y_ff   <= a_y_ff;
      b_ox4_ff <= a_ox4_ff;
      b_oy4_ff <= a_oy4_ff;

      rsp_x_ff <= sat_coord(rx);
      rsp_y_ff <= sat_coord(ry);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_last_of_run = rsp_last_ff;

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_valid) else $error("last_of_run without result");
   a_last_follows_fourth: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && (a_idx_ff == 2'(VERTEX_COUNT - 1))) |-> ##2 (rsp_valid && rsp_last_of_run))
      else $error("fourth vertex did not end the run");

endmodule
`default_nettype wire

// File: rtl/quad_vertex_transform_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quad_vertex_transform_top: scale / rotate / reflect of quadrilaterals
// Loads four vertices per quad and emits four transformed vertices.
// ----------------------------------------------------------------------------
// Use:
//   Input: a vertex beat is taken on a clock edge with start high and busy
//   low. Every fourth beat closes a quad.
//   Output: each result is shown for one cycle with rsp_valid high; the
//   fourth result of a quad carries rsp_last_of_run. The receiver cannot
//   stall, so results flow out at one per cycle.
//   Config: csr_write_en / csr_index / csr_data write one register per
//   edge; write only while no quad is in flight.
// Timing:
//   The first result of a quad leaves stage A, stage B and the result
//   register in turn once the quad is at the queue head; the others
//   follow at one per cycle. Sustained rate is one vertex per cycle, set
//   by the back pipeline handling one vertex a cycle. busy rises while
//   the two-entry quad queue is full. Quads in reflect mode with an
//   invalid axis, or an invalid mode, are consumed without results.
// Reset clears the vertex counter, the queue and all result strobes, and
//   loads the register defaults (unit scale, zero rotation).
// ----------------------------------------------------------------------------
module quad_vertex_transform_top #(
   parameter int COORD_BITS = 12
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire signed [COORD_BITS-1:0]          req_vertex_x,
   input  wire signed [COORD_BITS-1:0]          req_vertex_y,
   output logic                                 rsp_valid,
   output logic signed [COORD_BITS-1:0]         rsp_out_x,
   output logic signed [COORD_BITS-1:0]         rsp_out_y,
   output logic                                 rsp_last_of_run,
   input  wire                                  csr_write_en,
   input  wire [qvt_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  wire [qvt_pkg::CSR_DATA_BITS-1:0]     csr_data
);
   import qvt_pkg::*;

   localparam int DATA_BITS = 2 + 10 * COORD_BITS + 4;

   cfg_type              cfg_ff, cfg_in;
   logic                 accept;
   logic                 push, pop, q_full, q_not_empty;
   logic [DATA_BITS-1:0] push_data, head_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MODE:         cfg_in.mode         = csr_data[1:0];
            CSR_SCALE_X:      cfg_in.scale_x      = $signed(csr_data);
            CSR_SCALE_Y:      cfg_in.scale_y      = $signed(csr_data);
            CSR_ROTATE_COS:   cfg_in.rotate_cos   = $signed(csr_data);
            CSR_ROTATE_SIN:   cfg_in.rotate_sin   = $signed(csr_data);
            CSR_PIVOT_DX:     cfg_in.pivot_dx     = $signed(csr_data[PIVOT_BITS-1:0]);
            CSR_PIVOT_DY:     cfg_in.pivot_dy     = $signed(csr_data[PIVOT_BITS-1:0]);
            CSR_REFLECT_AXIS: cfg_in.reflect_axis = csr_data[1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode         <= MODE_SCALE;
         cfg_ff.scale_x      <= SCALE_RESET;
         cfg_ff.scale_y      <= SCALE_RESET;
         cfg_ff.rotate_cos   <= COS_RESET;
         cfg_ff.rotate_sin   <= '0;
         cfg_ff.pivot_dx     <= '0;
         cfg_ff.pivot_dy     <= '0;
         cfg_ff.reflect_axis <= AXIS_X;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign busy   = q_full;
   assign accept = start && !busy;

   qvt_front #(
      .COORD_BITS (COORD_BITS),
      .DATA_BITS  (DATA_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .vertex_x  (req_vertex_x),
      .vertex_y  (req_vertex_y),
      .cfg       (cfg_ff),
      .push      (push),
      .push_data (push_data)
   );

   qvt_queue #(
      .DATA_BITS (DATA_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_data (head_data)
   );

   qvt_back #(
      .COORD_BITS (COORD_BITS),
      .DATA_BITS  (DATA_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_not_empty),
      .head_data       (head_data),
      .cfg             (cfg_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
`default_nettype wire
